>>> hw/rtl/pce_pkg.sv
// ============================================================================
// pce_pkg : shared types, constants and tables of the pixel color effect unit
// Holds the pipeline item types, divider selects and the fire/ice blend tables.
// ============================================================================
package pce_pkg;

  // channel lanes
  localparam logic [1:0] LaneR = 2'd0;
  localparam logic [1:0] LaneG = 2'd1;
  localparam logic [1:0] LaneB = 2'd2;

  // effect constants
  localparam logic [7:0] FogLift    = 8'hFF;
  localparam logic [7:0] ShiftStep  = 8'h30;
  localparam logic [7:0] GrayLevel  = 8'h50;
  localparam logic [7:0] ShadeR     = 8'h19;
  localparam logic [7:0] ShadeG     = 8'h1E;
  localparam logic [7:0] ShadeB     = 8'h23;
  localparam logic [7:0] PinchTgtR  = 8'h8C;
  localparam logic [7:0] PinchTgtGB = 8'hDC;
  localparam logic [7:0] PinchStep  = 8'h28;
  localparam logic [7:0] HiliteMid  = 8'hA0;
  localparam logic [7:0] HiliteStep = 8'h0C;

  // reciprocals scaled by 2^RecipShift, exact over the dividend ranges used
  localparam int unsigned RecipShift = 20;
  localparam logic [17:0] Recip7  = 18'd149797;
  localparam logic [17:0] Recip11 = 18'd95326;
  localparam logic [17:0] Recip17 = 18'd61681;
  localparam logic [17:0] Recip63 = 18'd16645;

  // divider selects
  typedef enum logic [2:0] {
    DivNone,
    Div7,
    Div11,
    Div17,
    Div63
  } div_e;

  // item after the reduce and iteration stages
  typedef struct packed {
    logic [15:0] pix;
    logic        bank;
    logic [5:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } front_t;

  // one lane after effect decode: result = base + num / divisor
  typedef struct packed {
    logic signed [12:0] base;
    logic signed [15:0] num;
    div_e               dsel;
  } lane_a_t;

  // fire/ice blend colors {r, g, b} and strengths
  localparam logic [23:0] FireColor [3][15] = '{
    '{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF1000,
      24'hFF2000, 24'hFF3000, 24'hFF5000, 24'hFF8200, 24'hFFB420,
      24'hFFE640, 24'hFFFF60, 24'hFFFF80, 24'hFFFFA0, 24'hFFFFC8},
    '{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF1E00,
      24'hFF3C00, 24'hFF6400, 24'hFF9600, 24'hFFBE00, 24'hFFDC28,
      24'hFFFF32, 24'hFFFF64, 24'hFFFF96, 24'hFFFFC8, 24'hFFFFFF},
    '{24'h2828FF, 24'h2828FF, 24'h2828FF, 24'h2828FF, 24'h3C3CFF,
      24'h5050FF, 24'h6464FF, 24'h6464FF, 24'h7878FF, 24'h8C8CFF,
      24'hA0A0FF, 24'hB4B4FF, 24'hC8C8FF, 24'hDCDCFF, 24'hFFFFFF}
  };

  localparam logic [5:0] FireStrength [3][15] = '{
    '{6'd2, 6'd5, 6'd8, 6'd10, 6'd11, 6'd13, 6'd15, 6'd18,
      6'd24, 6'd30, 6'd35, 6'd39, 6'd43, 6'd47, 6'd52},
    '{6'd5, 6'd8, 6'd10, 6'd12, 6'd15, 6'd18, 6'd24, 6'd30,
      6'd35, 6'd42, 6'd47, 6'd52, 6'd57, 6'd63, 6'd63},
    '{6'd4, 6'd7, 6'd9, 6'd11, 6'd13, 6'd17, 6'd22, 6'd27,
      6'd32, 6'd37, 6'd42, 6'd47, 6'd52, 6'd57, 6'd60}
  };

  function automatic logic fire_defined(input logic [1:0] grp, input logic [3:0] lvl);
    return (grp != 2'd3) && (lvl != 4'd15);
  endfunction

  function automatic logic [23:0] fire_color(input logic [1:0] grp, input logic [3:0] lvl);
    logic [23:0] col;
    col = '0;
    if (fire_defined(grp, lvl)) begin
      col = FireColor[grp][lvl];
    end
    return col;
  endfunction

  function automatic logic [5:0] fire_strength(input logic [1:0] grp, input logic [3:0] lvl);
    logic [5:0] str;
    str = '0;
    if (fire_defined(grp, lvl)) begin
      str = FireStrength[grp][lvl];
    end
    return str;
  endfunction

endpackage

>>> hw/rtl/pce_front.sv
// ============================================================================
// pce_front : channel reduce and iterated effect stages
// Cuts each channel to 4 bits and widens it, then runs four iteration stages
// for fog to white and the red highlight steps.
// ============================================================================
module pce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     pixel_in_i,
  input  logic            table_bank_i,
  input  logic [5:0]      table_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pce_pkg::front_t out_item_o
);
  import pce_pkg::*;

  localparam int Stages = 5;

  front_t             item_q [Stages];
  front_t             item_d [Stages];
  logic [Stages-1:0]  vld_q;
  logic [Stages-1:0]  vld_d;
  logic [Stages:0]    take;

  // fog to white step: (4c + 255) / 5
  function automatic logic [7:0] fog_white(input logic [7:0] c);
    logic [10:0] x;
    logic [24:0] p;
    x = {1'b0, c, 2'b00} + {3'b000, FogLift};
    p = 25'(x) * 25'd13108;
    return p[23:16];
  endfunction

  // one iteration, j counts from zero
  function automatic front_t iter_step(input front_t it, input logic [1:0] j);
    front_t o;
    logic   do_fog;
    logic   do_hl;
    o      = it;
    do_fog = !it.bank && (it.idx <= 6'd3) && ({4'b0000, j} <= it.idx);
    do_hl  = !it.bank && (it.idx >= 6'd24) && (it.idx <= 6'd27)
             && ((6'd24 + {4'b0000, j}) <= it.idx);
    if (do_fog) begin
      o.r = fog_white(it.r);
      o.g = fog_white(it.g);
      o.b = fog_white(it.b);
    end else if (do_hl) begin
      o.r = (it.r < HiliteMid) ? it.r + HiliteStep : it.r - HiliteStep;
    end
    return o;
  endfunction

  // channel reduce to 4 bits, reciprocal multiply in place of / 31 and / 63
  logic [8:0]  r_x;
  logic [8:0]  b_x;
  logic [9:0]  g_x;
  logic [24:0] r_p;
  logic [24:0] g_p;
  logic [24:0] b_p;

  always_comb begin
    r_x = 9'(pixel_in_i[15:11]) * 9'd15;
    g_x = 10'(pixel_in_i[10:5]) * 10'd15;
    b_x = 9'(pixel_in_i[4:0]) * 9'd15;
    r_p = 25'(r_x) * 25'd33826;
    g_p = 25'(g_x) * 25'd16645;
    b_p = 25'(b_x) * 25'd33826;
  end

  // next stage values
  always_comb begin
    item_d[0].pix  = pixel_in_i;
    item_d[0].bank = table_bank_i;
    item_d[0].idx  = table_index_i;
    item_d[0].r    = {r_p[23:20], r_p[23:20]};
    item_d[0].g    = {g_p[23:20], g_p[23:20]};
    item_d[0].b    = {b_p[23:20], b_p[23:20]};
    for (int k = 1; k < Stages; k++) begin
      item_d[k] = iter_step(item_q[k-1], 2'(k - 1));
    end
  end

  // per stage flow control, a stage moves when it is empty or its successor moves
  always_comb begin
    take[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
    vld_d = {vld_q[Stages-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (take[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (take[k] && vld_d[k]) begin
        item_q[k] <= item_d[k];
      end
    end
  end

  assign in_ready_o  = take[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_item_o  = item_q[Stages-1];

endmodule

>>> hw/rtl/pce_arith.sv
// ============================================================================
// pce_arith : effect decode, constant divide and clamp/pack stages
// Stage A forms base and dividend per lane, stage B divides by reciprocal,
// stage C adds, clamps to 0..255 and packs to RGB565.
// ============================================================================
module pce_arith (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pce_pkg::front_t in_item_i,
  input  logic [15:0]     bg_color_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     pixel_out_o,
  output logic            table_defined_o
);
  import pce_pkg::*;

  typedef struct packed {
    logic [15:0]        pix;
    logic               defined;
    lane_a_t [2:0]      lane;
  } stage_a_t;

  typedef struct packed {
    logic [15:0]              pix;
    logic                     defined;
    logic [2:0][12:0]         base;
    logic [2:0][12:0]         quot;
  } stage_b_t;

  stage_a_t    a_d, a_q;
  stage_b_t    b_d, b_q;
  logic [15:0] pix_d, pix_q;
  logic        def_d, def_q;
  logic [2:0]  vld_q;
  logic [3:0]  take;

  // effect decode for one lane
  function automatic lane_a_t lane_decode(
    input logic       bank,
    input logic [5:0] idx,
    input logic [1:0] lane,
    input logic [7:0] c,
    input logic [7:0] t_bg,
    input logic [7:0] t_fire,
    input logic [5:0] str
  );
    lane_a_t            o;
    logic signed [12:0] cs;
    logic signed [12:0] ds;
    logic signed [12:0] tgt;
    logic signed [12:0] stp;
    logic signed [9:0]  diff_bg;
    logic signed [9:0]  diff_fire;
    logic signed [9:0]  diff_gray;
    logic [7:0]         d48;
    logic [11:0]        dim_p;
    logic [3:0]         lv;
    logic [2:0]         gl;
    logic [4:0]         s;
    logic [6:0]         hl;
    logic               up;
    cs        = $signed({5'b00000, c});
    diff_bg   = $signed({2'b00, t_bg}) - $signed({2'b00, c});
    diff_fire = $signed({2'b00, t_fire}) - $signed({2'b00, c});
    diff_gray = $signed({2'b00, GrayLevel}) - $signed({2'b00, c});
    o.base    = cs;
    o.num     = '0;
    o.dsel    = DivNone;
    d48       = '0;
    up        = 1'b0;
    if (bank) begin
      o.num  = 16'(diff_fire) * $signed({10'b0, str});
      o.dsel = Div63;
    end else if (idx <= 6'd3) begin
      o.base = cs;
    end else if (idx <= 6'd11) begin
      // dimming
      lv     = 4'(6'd14 - idx);
      dim_p  = 12'(c) * 12'(lv);
      o.base = '0;
      o.num  = $signed({4'b0000, dim_p});
      o.dsel = Div11;
    end else if (idx <= 6'd17) begin
      // cold, warm and red shifts
      if (idx <= 6'd13) begin
        d48 = ShiftStep * 8'(idx - 6'd11);
        up  = (lane == LaneG);
      end else if (idx <= 6'd15) begin
        d48 = ShiftStep * 8'(idx - 6'd13);
        up  = (lane != LaneB);
      end else begin
        d48 = ShiftStep * 8'(idx - 6'd15);
        up  = (lane == LaneR);
      end
      ds     = $signed({5'b00000, d48});
      o.base = up ? cs + ds : cs - ds;
    end else if (idx <= 6'd21) begin
      // fog to gray
      gl     = 3'(idx - 6'd17);
      o.num  = 16'(diff_gray) * $signed({13'b0, gl});
      o.dsel = Div7;
    end else if (idx == 6'd22) begin
      // shadow
      case (lane)
        LaneR:   o.base = $signed({5'b00000, ShadeR}) - cs;
        LaneG:   o.base = $signed({5'b00000, ShadeG}) - cs;
        default: o.base = $signed({5'b00000, ShadeB}) - cs;
      endcase
    end else if (idx == 6'd23) begin
      // contrast pinch, no crossing of the target
      tgt = (lane == LaneR) ? $signed({5'b00000, PinchTgtR})
                            : $signed({5'b00000, PinchTgtGB});
      if (cs > tgt) begin
        stp    = cs - $signed({5'b00000, PinchStep});
        o.base = (stp < tgt) ? tgt : stp;
      end else begin
        stp    = cs + $signed({5'b00000, PinchStep});
        o.base = (stp > tgt) ? tgt : stp;
      end
    end else if (idx <= 6'd27) begin
      // highlight, red already stepped upstream
      if (lane != LaneR) begin
        hl     = {3'(idx - 6'd23), 4'b0000};
        o.base = cs - $signed({6'b000000, hl});
      end
    end else if (idx >= 6'd32 && idx <= 6'd47) begin
      // blend to background
      s      = 5'(idx - 6'd31);
      o.num  = 16'(diff_bg) * $signed({11'b0, s});
      o.dsel = Div17;
    end
    return o;
  endfunction

  // stage A: decode
  logic [23:0] fcol;
  logic [5:0]  fstr;
  logic [7:0]  bg_r, bg_g, bg_b;

  always_comb begin
    fcol = fire_color(in_item_i.idx[5:4], in_item_i.idx[3:0]);
    fstr = fire_strength(in_item_i.idx[5:4], in_item_i.idx[3:0]);
    bg_r = {bg_color_i[15:11], 3'b000};
    bg_g = {bg_color_i[10:5], 2'b00};
    bg_b = {bg_color_i[4:0], 3'b000};
    a_d.pix = in_item_i.pix;
    if (in_item_i.bank) begin
      a_d.defined = fire_defined(in_item_i.idx[5:4], in_item_i.idx[3:0]);
    end else begin
      a_d.defined = (in_item_i.idx <= 6'd27)
                    || (in_item_i.idx >= 6'd32 && in_item_i.idx <= 6'd47);
    end
    a_d.lane[0] = lane_decode(in_item_i.bank, in_item_i.idx, LaneR, in_item_i.r,
                              bg_r, fcol[23:16], fstr);
    a_d.lane[1] = lane_decode(in_item_i.bank, in_item_i.idx, LaneG, in_item_i.g,
                              bg_g, fcol[15:8], fstr);
    a_d.lane[2] = lane_decode(in_item_i.bank, in_item_i.idx, LaneB, in_item_i.b,
                              bg_b, fcol[7:0], fstr);
  end

  // stage B: divide by reciprocal multiply, truncating toward zero
  logic [2:0][15:0] mag;
  logic [2:0][17:0] recip;
  logic [2:0][32:0] prod;
  logic [2:0][11:0] qmag;

  always_comb begin
    b_d.pix     = a_q.pix;
    b_d.defined = a_q.defined;
    for (int k = 0; k < 3; k++) begin
      mag[k] = a_q.lane[k].num[15] ? 16'(-a_q.lane[k].num) : 16'(a_q.lane[k].num);
      case (a_q.lane[k].dsel)
        Div7:    recip[k] = Recip7;
        Div11:   recip[k] = Recip11;
        Div17:   recip[k] = Recip17;
        Div63:   recip[k] = Recip63;
        default: recip[k] = '0;
      endcase
      prod[k]     = 33'(mag[k][14:0]) * 33'(recip[k]);
      qmag[k]     = prod[k][RecipShift+11:RecipShift];
      b_d.base[k] = a_q.lane[k].base;
      b_d.quot[k] = a_q.lane[k].num[15] ? 13'(-$signed({1'b0, qmag[k]}))
                                        : {1'b0, qmag[k]};
    end
  end

  // stage C: add, clamp and pack
  logic signed [13:0] sum [3];
  logic [7:0]         ch8 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 14'($signed(b_q.base[k])) + 14'($signed(b_q.quot[k]));
      if (sum[k] < 0) begin
        ch8[k] = 8'd0;
      end else if (sum[k] > 14'sd255) begin
        ch8[k] = 8'd255;
      end else begin
        ch8[k] = sum[k][7:0];
      end
    end
    pix_d = b_q.defined ? {ch8[0][7:3], ch8[1][7:2], ch8[2][7:3]} : b_q.pix;
    def_d = b_q.defined;
  end

  // flow control
  always_comb begin
    take[3] = out_ready_i;
    for (int k = 2; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (take[0]) vld_q[0] <= in_valid_i;
      if (take[1]) vld_q[1] <= vld_q[0];
      if (take[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0] && in_valid_i) a_q <= a_d;
    if (take[1] && vld_q[0])   b_q <= b_d;
    if (take[2] && vld_q[1]) begin
      pix_q <= pix_d;
      def_q <= def_d;
    end
  end

  assign in_ready_o      = take[0];
  assign out_valid_o     = vld_q[2];
  assign pixel_out_o     = pix_q;
  assign table_defined_o = def_q;

endmodule

>>> hw/rtl/pixel_color_effect_unit.sv
// ============================================================================
// pixel_color_effect_unit : RGB565 recolor pipeline
// Recolors one pixel per clock when not stalled, through a bank 0 color
// effect or a bank 1 fire/ice blend, with a background color register for
// blend effects.
// Usage
//   Input channel in_valid_i/in_ready_o carries pixel_in_i, table_bank_i and
//   table_index_i. Output channel out_valid_o/out_ready_i carries pixel_out_o
//   and table_defined_o. Indices with no table return the pixel unchanged
//   with table_defined_o low.
//   Configuration channel cfg_valid_i/cfg_ready_o writes background_color_i;
//   it is always ready. Write it only while no item is in flight.
//   The pipe has one reduce stage, four iteration stages for fog to
//   white and highlight steps, then decode, divide and clamp/pack stages.
//   Throughput is one item per cycle when not stalled; each stage holds its
//   own valid bit. When the receiver stalls, items pile up stage by stage
//   and in_ready_o drops only once every stage is full; nothing is lost or
//   repeated. Reset clears all valid bits and the background color to zero.
// ============================================================================
module pixel_color_effect_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_in_i,
  input  logic        table_bank_i,
  input  logic [5:0]  table_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pixel_out_o,
  output logic        table_defined_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] background_color_i
);
  import pce_pkg::*;

  front_t      mid_item;
  logic        mid_valid;
  logic        mid_ready;
  logic [15:0] bg_q;

  // background color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0;
    end else if (cfg_valid_i) begin
      bg_q <= background_color_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // reduce and iteration stages
  pce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_in_i    (pixel_in_i),
    .table_bank_i  (table_bank_i),
    .table_index_i (table_index_i),
    .out_valid_o   (mid_valid),
    .out_ready_i   (mid_ready),
    .out_item_o    (mid_item)
  );

  // decode, divide and pack stages
  pce_arith u_arith (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .in_item_i       (mid_item),
    .bg_color_i      (bg_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_out_o     (pixel_out_o),
    .table_defined_o (table_defined_o)
  );

endmodule

>>> hw/rtl/pce_checker.sv
// ============================================================================
// pce_checker : port level checks of the pixel color effect unit
// Watches reset, stall and flow control behavior seen on the top level ports.
// ============================================================================
module pce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pixel_out_o,
  input logic        table_defined_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // no item shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output item valid during reset");

  // a stalled item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(table_defined_o))
    else $error("stalled output item changed");

  // with the output stage empty the whole pipe can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output stage empty");

  // configuration never blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write blocked");

endmodule

bind pixel_color_effect_unit pce_checker u_pce_checker (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : testbench of the pixel color effect unit
// Drives pixels through every effect of both banks under several background
// colors, predicts each recolored pixel and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchLimit = 5000;
  localparam int DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] pixel_in_i;
  logic        table_bank_i;
  logic [5:0]  table_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] pixel_out_o;
  logic        table_defined_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] background_color_i;

  typedef struct packed {
    logic [15:0] pix;
    logic        defined;
  } recolor_t;

  recolor_t    expected_q[$];
  logic [15:0] bg_color;
  int          error_count;
  int          item_count;
  int          result_count;
  int          idle_count;
  bit          busy_send;
  bit          quiet_phase;

  pixel_color_effect_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pixel_in_i(pixel_in_i), .table_bank_i(table_bank_i),
    .table_index_i(table_index_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o), .table_defined_o(table_defined_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .background_color_i(background_color_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fire and ice blend tables
  function automatic logic [23:0] blend_target(int grp, int lvl);
    logic [23:0] tab [3][15];
    tab = '{
      '{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF1000,
        24'hFF2000, 24'hFF3000, 24'hFF5000, 24'hFF8200, 24'hFFB420,
        24'hFFE640, 24'hFFFF60, 24'hFFFF80, 24'hFFFFA0, 24'hFFFFC8},
      '{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF1E00,
        24'hFF3C00, 24'hFF6400, 24'hFF9600, 24'hFFBE00, 24'hFFDC28,
        24'hFFFF32, 24'hFFFF64, 24'hFFFF96, 24'hFFFFC8, 24'hFFFFFF},
      '{24'h2828FF, 24'h2828FF, 24'h2828FF, 24'h2828FF, 24'h3C3CFF,
        24'h5050FF, 24'h6464FF, 24'h6464FF, 24'h7878FF, 24'h8C8CFF,
        24'hA0A0FF, 24'hB4B4FF, 24'hC8C8FF, 24'hDCDCFF, 24'hFFFFFF}
    };
    return tab[grp][lvl];
  endfunction

  function automatic int blend_weight(int grp, int lvl);
    int w [3][15];
    w = '{
      '{2, 5, 8, 10, 11, 13, 15, 18, 24, 30, 35, 39, 43, 47, 52},
      '{5, 8, 10, 12, 15, 18, 24, 30, 35, 42, 47, 52, 57, 63, 63},
      '{4, 7, 9, 11, 13, 17, 22, 27, 32, 37, 42, 47, 52, 57, 60}
    };
    return w[grp][lvl];
  endfunction

  function automatic int pinch(int c, int tgt);
    int v;
    if (c > tgt) begin
      v = c - 40;
      if (v < tgt) v = tgt;
    end else begin
      v = c + 40;
      if (v > tgt) v = tgt;
    end
    return v;
  endfunction

  function automatic int sat8(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // expected recolored pixel; SV int division truncates toward zero
  function automatic recolor_t recolor(logic [15:0] pix, logic bank, logic [5:0] idx,
                                       logic [15:0] bg);
    int       ch[3];
    int       tc[3];
    int       n;
    int       grp;
    int       lvl;
    int       a;
    logic     ok;
    logic [23:0] col;
    recolor_t res;
    ch[0] = ((int'(pix[15:11]) * 15) / 31) * 17;
    ch[1] = ((int'(pix[10:5]) * 15) / 63) * 17;
    ch[2] = ((int'(pix[4:0]) * 15) / 31) * 17;
    ok = 1'b1;
    if (bank == 1'b0) begin
      n = idx;
      if (n <= 3) begin
        for (int i = 0; i <= n; i++)
          for (int k = 0; k < 3; k++) ch[k] = (ch[k] * 4 + 255) / 5;
      end else if (n <= 11) begin
        for (int k = 0; k < 3; k++) ch[k] = ch[k] * (14 - n) / 11;
      end else if (n <= 13) begin
        ch[0] -= 48 * (n - 11); ch[1] += 48 * (n - 11); ch[2] -= 48 * (n - 11);
      end else if (n <= 15) begin
        ch[0] += 48 * (n - 13); ch[1] += 48 * (n - 13); ch[2] -= 48 * (n - 13);
      end else if (n <= 17) begin
        ch[0] += 48 * (n - 15); ch[1] -= 48 * (n - 15); ch[2] -= 48 * (n - 15);
      end else if (n <= 21) begin
        for (int k = 0; k < 3; k++)
          ch[k] = ch[k] + (int'(8'h50) - ch[k]) * (n - 17) / 7;
      end else if (n == 22) begin
        ch[0] = 8'h19 - ch[0]; ch[1] = 8'h1E - ch[1]; ch[2] = 8'h23 - ch[2];
      end else if (n == 23) begin
        ch[0] = pinch(ch[0], 8'h8C);
        ch[1] = pinch(ch[1], 8'hDC);
        ch[2] = pinch(ch[2], 8'hDC);
      end else if (n <= 27) begin
        for (int i = 0; i < n - 23; i++) ch[0] += (ch[0] < 8'hA0) ? 12 : -12;
        ch[1] -= 16 * (n - 23);
        ch[2] -= 16 * (n - 23);
      end else if (n >= 32 && n <= 47) begin
        tc[0] = int'(bg[15:11]) << 3;
        tc[1] = int'(bg[10:5]) << 2;
        tc[2] = int'(bg[4:0]) << 3;
        for (int k = 0; k < 3; k++) ch[k] = ch[k] + (tc[k] - ch[k]) * (n - 31) / 17;
      end else begin
        ok = 1'b0;
      end
    end else begin
      grp = idx[5:4];
      lvl = idx[3:0];
      ok = (grp < 3) && (lvl < 15);
      if (ok) begin
        col = blend_target(grp, lvl);
        a = blend_weight(grp, lvl);
        tc[0] = col[23:16]; tc[1] = col[15:8]; tc[2] = col[7:0];
        for (int k = 0; k < 3; k++) ch[k] = ch[k] + (tc[k] - ch[k]) * a / 63;
      end
    end
    if (ok) begin
      for (int k = 0; k < 3; k++) ch[k] = sat8(ch[k]);
      res.pix = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
      res.defined = 1'b1;
    end else begin
      res.pix = pix;
      res.defined = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("tb_top: mismatch after %0d results: %s", result_count, what);
    error_count++;
  endtask

  // send one pixel item, predicting its result on acceptance
  task automatic send_pixel(logic [15:0] pix, logic bank, logic [5:0] idx);
    while (!quiet_phase && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    table_bank_i  <= bank;
    table_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(recolor(pix, bank, idx, bg_color));
    item_count++;
    @(negedge clk_i);
  endtask

  // wait for all results, then write the background color
  task automatic write_background(logic [15:0] value);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i        <= 1'b1;
    background_color_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    bg_color = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= quiet_phase || ($urandom_range(99) >= 15);
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    recolor_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (pixel_out_o !== want.pix)
            report_mismatch($sformatf("pixel_out %h, want %h", pixel_out_o, want.pix));
          if (table_defined_o !== want.defined)
            report_mismatch($sformatf("table_defined %b, want %b",
                                      table_defined_o, want.defined));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || expected_q.size() == 0 && !busy_send) idle_count = 0;
      else idle_count++;
      if (idle_count >= WatchLimit) begin
        $display("tb_top: watchdog expired");
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic test_field_extremes();
    send_pixel(16'h0000, 1'b0, 6'd0);
    send_pixel(16'hFFFF, 1'b0, 6'd0);
    send_pixel(16'hFFFF, 1'b1, 6'd46);
    send_pixel(16'h0000, 1'b1, 6'd63);
    send_pixel(16'hF800, 1'b0, 6'd63);
    send_pixel(16'h07E0, 1'b0, 6'd22);
    send_pixel(16'h001F, 1'b0, 6'd23);
  endtask

  task automatic test_bank0_effects();
    for (int i = 0; i < 64; i += 3) send_pixel(16'($urandom), 1'b0, 6'(i));
    send_pixel(16'hFFFF, 1'b0, 6'd28);
    send_pixel(16'h8410, 1'b0, 6'd31);
  endtask

  task automatic test_bank1_effects();
    send_pixel(16'hFFFF, 1'b1, 6'd15);
    send_pixel(16'h1234, 1'b1, 6'd48);
    send_pixel(16'h0000, 1'b1, 6'd29);
  endtask

  task automatic test_random_pixels(int count, logic [15:0] bg);
    int sel;
    write_background(bg);
    for (int i = 0; i < count; i++) begin
      quiet_phase = (i >= count / 2) && (i < count / 2 + 40);
      sel = $urandom_range(9);
      // mostly defined tables, some undefined indices
      if (sel < 5) send_pixel(16'($urandom), 1'b0, 6'($urandom_range(27)));
      else if (sel < 7) send_pixel(16'($urandom), 1'b0, 6'($urandom_range(47, 32)));
      else if (sel < 9) send_pixel(16'($urandom), 1'b1, 6'($urandom_range(46)));
      else send_pixel(16'($urandom), 1'($urandom), 6'($urandom));
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_in_i = '0;
    table_bank_i = 1'b0;
    table_index_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    background_color_i = '0;
    bg_color = '0;
    error_count = 0;
    item_count = 0;
    result_count = 0;
    idle_count = 0;
    quiet_phase = 1'b0;
    busy_send = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_field_extremes();
    test_bank0_effects();
    test_bank1_effects();
    test_random_pixels(150, 16'hFFFF);
    test_random_pixels(150, 16'h0000);
    test_random_pixels(150, 16'($urandom));
    test_random_pixels(150, 16'($urandom));
    in_valid_i <= 1'b0;
    busy_send = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("tb_top: %0d pixels over both banks, %0d results checked, 4 background colors",
             item_count, result_count);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pce_pkg.sv
hw/rtl/pce_front.sv
hw/rtl/pce_arith.sv
hw/rtl/pixel_color_effect_unit.sv
hw/rtl/pce_checker.sv
test/tb_top.sv
